[src/s2cd_pkg.sv]
// ----------------------------------------------------------------------------
// s2cd_pkg - shared types and constants for the seconds to calendar converter
// command and status records between controller and datapath, divider
// operation codes, controller states and the small calendar tables
// ----------------------------------------------------------------------------
`default_nettype none

package s2cd_pkg;

  // datapath widths
  localparam int DVD_W  = 32;  // divider dividend and quotient
  localparam int REM_W  = 9;   // divider remainder, divisors up to 400
  localparam int YEAR_W = 13;  // unwrapped year, also year plus 400
  localparam int DAYS_W = 16;  // whole days in a 32-bit second count
  localparam int SUM_W  = 14;  // weekday formula sum before mod 7
  localparam int BASE_W = 12;  // base year register

  localparam logic [BASE_W-1:0] BASE_YEAR_RST = 12'd2000;

  // divisors
  localparam logic [REM_W-1:0] SEC_PER_MIN  = 9'd60;
  localparam logic [REM_W-1:0] MIN_PER_HOUR = 9'd60;
  localparam logic [REM_W-1:0] HOUR_PER_DAY = 9'd24;
  localparam logic [REM_W-1:0] YEARS_C100   = 9'd100;
  localparam logic [REM_W-1:0] YEARS_C400   = 9'd400;
  localparam logic [REM_W-1:0] DAYS_WEEK    = 9'd7;

  // rounded-up reciprocals and their shifts, exact for any 32-bit dividend
  localparam logic [DVD_W-1:0] RCP_60  = 32'h8888_8889;  // ceil(2^37 / 60)
  localparam int               SH_60   = 37;
  localparam logic [DVD_W-1:0] RCP_24  = 32'hAAAA_AAAB;  // ceil(2^36 / 24)
  localparam int               SH_24   = 36;
  localparam logic [DVD_W-1:0] RCP_100 = 32'h51EB_851F;  // ceil(2^37 / 100)
  localparam int               SH_100  = 37;
  localparam int               SH_400  = 39;             // same reciprocal, 2^39 / 400
  // exact only for dividends below 2^14, which covers the weekday sum
  localparam logic [DVD_W-1:0] RCP_7   = 32'd18725;      // ceil(2^17 / 7)
  localparam int               SH_7    = 17;

  typedef enum logic [2:0] {
    DOP_SEC,   // seconds / 60
    DOP_MIN,   // minutes / 60
    DOP_HR,    // hours / 24
    DOP_BASE,  // base year mod 400
    DOP_C100,  // weekday year / 100
    DOP_C400,  // weekday year / 400
    DOP_WD     // weekday sum mod 7
  } div_op_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_SEC   = 10'b00_0000_0010,
    ST_MIN   = 10'b00_0000_0100,
    ST_HR    = 10'b00_0000_1000,
    ST_BASE  = 10'b00_0001_0000,
    ST_YEAR  = 10'b00_0010_0000,
    ST_MONTH = 10'b00_0100_0000,
    ST_C100  = 10'b00_1000_0000,
    ST_C400  = 10'b01_0000_0000,
    ST_WD    = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic    div_go;
    div_op_t go_op;
    logic    div_cap;
    div_op_t cap_op;
    logic    year_step;
    logic    month_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic year_fit;
    logic month_done;
  } dp_stat_t;

  // days in month, month index from 0
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // floor(3 * (mm + 1) / 5) for march-based month numbers 3 to 14
  function automatic logic [3:0] kl_month_term(input logic [3:0] mm);
    logic [3:0] t;
    unique case (mm)
      4'd3:    t = 4'd2;
      4'd4:    t = 4'd3;
      4'd5:    t = 4'd3;
      4'd6:    t = 4'd4;
      4'd7:    t = 4'd4;
      4'd8:    t = 4'd5;
      4'd9:    t = 4'd6;
      4'd10:   t = 4'd6;
      4'd11:   t = 4'd7;
      4'd12:   t = 4'd7;
      4'd13:   t = 4'd8;
      4'd14:   t = 4'd9;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

[src/s2cd_div.sv]
// ----------------------------------------------------------------------------
// s2cd_div - constant divider by reciprocal multiplication
// pipeline: operand capture, multiply, quotient by shift, remainder by back-multiply
// ----------------------------------------------------------------------------
`default_nettype none

module s2cd_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           go,
  input  wire s2cd_pkg::div_op_t              op_in,
  input  wire logic [s2cd_pkg::DVD_W-1:0]     dvd_in,
  output logic                                done,
  output logic      [s2cd_pkg::DVD_W-1:0]     quo,
  output logic      [s2cd_pkg::REM_W-1:0]     rem
);

  localparam int DVD_W = s2cd_pkg::DVD_W;
  localparam int REM_W = s2cd_pkg::REM_W;
  localparam int PRD_W = 2 * DVD_W;

  logic [3:0]        vld_r;
  s2cd_pkg::div_op_t op_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [PRD_W-1:0]  prod_r;
  logic [DVD_W-1:0]  quo_r;
  logic [REM_W-1:0]  rem_r;

  logic [DVD_W-1:0]  rcp;
  logic [DVD_W-1:0]  quo_nxt;
  logic [DVD_W-1:0]  qd;
  logic [DVD_W-1:0]  rem_full;

  // reciprocal and quotient bits per operation
  always_comb begin
    case (op_r) inside
      s2cd_pkg::DOP_SEC, s2cd_pkg::DOP_MIN: begin
        rcp     = s2cd_pkg::RCP_60;
        quo_nxt = DVD_W'(prod_r[PRD_W-1:s2cd_pkg::SH_60]);
      end
      s2cd_pkg::DOP_HR: begin
        rcp     = s2cd_pkg::RCP_24;
        quo_nxt = DVD_W'(prod_r[PRD_W-1:s2cd_pkg::SH_24]);
      end
      s2cd_pkg::DOP_BASE, s2cd_pkg::DOP_C400: begin
        rcp     = s2cd_pkg::RCP_100;
        quo_nxt = DVD_W'(prod_r[PRD_W-1:s2cd_pkg::SH_400]);
      end
      s2cd_pkg::DOP_C100: begin
        rcp     = s2cd_pkg::RCP_100;
        quo_nxt = DVD_W'(prod_r[PRD_W-1:s2cd_pkg::SH_100]);
      end
      s2cd_pkg::DOP_WD: begin
        rcp     = s2cd_pkg::RCP_7;
        quo_nxt = DVD_W'(prod_r[PRD_W-1:s2cd_pkg::SH_7]);
      end
      default: begin
        rcp     = '0;
        quo_nxt = '0;
      end
    endcase
  end

  // quotient times divisor, each arm a constant multiply
  always_comb begin
    case (op_r)
      s2cd_pkg::DOP_SEC:  qd = quo_r * DVD_W'(s2cd_pkg::SEC_PER_MIN);
      s2cd_pkg::DOP_MIN:  qd = quo_r * DVD_W'(s2cd_pkg::MIN_PER_HOUR);
      s2cd_pkg::DOP_HR:   qd = quo_r * DVD_W'(s2cd_pkg::HOUR_PER_DAY);
      s2cd_pkg::DOP_BASE: qd = quo_r * DVD_W'(s2cd_pkg::YEARS_C400);
      s2cd_pkg::DOP_C100: qd = quo_r * DVD_W'(s2cd_pkg::YEARS_C100);
      s2cd_pkg::DOP_C400: qd = quo_r * DVD_W'(s2cd_pkg::YEARS_C400);
      s2cd_pkg::DOP_WD:   qd = quo_r * DVD_W'(s2cd_pkg::DAYS_WEEK);
      default:            qd = '0;
    endcase
    // remainder stays below the divisor, so the low bits hold it
    rem_full = dvd_r - qd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], go};
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd_r <= dvd_in;
      op_r  <= op_in;
    end
    if (vld_r[0]) begin
      prod_r <= PRD_W'(dvd_r) * PRD_W'(rcp);
    end
    if (vld_r[1]) begin
      quo_r <= quo_nxt;
    end
    if (vld_r[2]) begin
      rem_r <= rem_full[REM_W-1:0];
    end
  end

  assign done = vld_r[3];
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

[src/s2cd_dp.sv]
// ----------------------------------------------------------------------------
// s2cd_dp - datapath of the seconds to calendar converter
// base year register, shared divider, year and month peeling, weekday sum
// and the result registers
// ----------------------------------------------------------------------------
`default_nettype none

module s2cd_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [31:0]                     in_elapsed_seconds,
  input  wire logic                            cfg_we,
  input  wire logic [s2cd_pkg::BASE_W-1:0]     cfg_base_year,
  input  wire s2cd_pkg::ctrl_cmd_t             cmd,
  output s2cd_pkg::dp_stat_t                   stat,
  output logic                                 out_valid,
  output logic      [11:0]                     out_year,
  output logic      [3:0]                      out_month,
  output logic      [4:0]                      out_day,
  output logic      [4:0]                      out_hour,
  output logic      [5:0]                      out_minute,
  output logic      [5:0]                      out_second,
  output logic      [2:0]                      out_weekday
);

  localparam int DVD_W  = s2cd_pkg::DVD_W;
  localparam int REM_W  = s2cd_pkg::REM_W;
  localparam int YEAR_W = s2cd_pkg::YEAR_W;
  localparam int DAYS_W = s2cd_pkg::DAYS_W;
  localparam int SUM_W  = s2cd_pkg::SUM_W;
  localparam int BASE_W = s2cd_pkg::BASE_W;

  // year mod 100 from year mod 400
  function automatic logic [6:0] mod100(input logic [REM_W-1:0] r400);
    logic [REM_W-1:0] r;
    if (r400 >= 9'd300)      r = r400 - 9'd300;
    else if (r400 >= 9'd200) r = r400 - 9'd200;
    else if (r400 >= 9'd100) r = r400 - 9'd100;
    else                     r = r400;
    return r[6:0];
  endfunction

  logic [BASE_W-1:0] base_year_r;

  logic [5:0]        sec_r;
  logic [5:0]        min_r;
  logic [4:0]        hour_r;
  logic [DAYS_W-1:0] days_r;
  logic [YEAR_W-1:0] year_r;
  logic [REM_W-1:0]  r400_r;
  logic [6:0]        r100_r;
  logic [3:0]        m_r;
  logic [5:0]        c100_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [11:0]       out_year_r;
  logic [3:0]        out_month_r;
  logic [4:0]        out_day_r;
  logic [4:0]        out_hour_r;
  logic [5:0]        out_minute_r;
  logic [5:0]        out_second_r;
  logic [2:0]        out_weekday_r;

  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic [REM_W-1:0]  div_rem;
  logic [DVD_W-1:0]  div_dvd;

  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        mlen;
  logic [3:0]        mm_kl;
  logic [YEAR_W-1:0] yy;
  logic [SUM_W-1:0]  wd_sum;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_year_r <= s2cd_pkg::BASE_YEAR_RST;
    end else if (cfg_we) begin
      base_year_r <= cfg_base_year;
    end
  end

  // leap status of the current year from its mod counters
  always_comb begin
    leap = (year_r[1:0] == 2'd0) && ((r100_r != 7'd0) || (r400_r == '0));
    ylen = leap ? 9'd366 : 9'd365;
    mlen = s2cd_pkg::month_len(m_r, leap);
    stat.div_done   = div_done;
    stat.year_fit   = (days_r < DAYS_W'(ylen));
    stat.month_done = (m_r == 4'd11) || (days_r < DAYS_W'(mlen));
  end

  // weekday formula terms, jan and feb as months 13 and 14 of the year before
  always_comb begin
    if (m_r < 4'd2) begin
      mm_kl = m_r + 4'd13;
      yy    = year_r + YEAR_W'(399);
    end else begin
      mm_kl = m_r + 4'd1;
      yy    = year_r + YEAR_W'(400);
    end
    // year / 400 is taken straight off the divider as it finishes
    wd_sum = SUM_W'(days_r[4:0]) + SUM_W'(1)
           + SUM_W'({mm_kl, 1'b0})
           + SUM_W'(s2cd_pkg::kl_month_term(mm_kl))
           + SUM_W'(yy) + SUM_W'(yy[YEAR_W-1:2])
           - SUM_W'(c100_r) + SUM_W'(div_quo[3:0]);
  end

  // divider operand selection
  always_comb begin
    case (cmd.go_op)
      s2cd_pkg::DOP_SEC:  div_dvd = in_elapsed_seconds;
      s2cd_pkg::DOP_MIN:  div_dvd = div_quo;
      s2cd_pkg::DOP_HR:   div_dvd = div_quo;
      s2cd_pkg::DOP_BASE: div_dvd = DVD_W'(base_year_r);
      s2cd_pkg::DOP_C100: div_dvd = DVD_W'(yy);
      s2cd_pkg::DOP_C400: div_dvd = DVD_W'(yy);
      s2cd_pkg::DOP_WD:   div_dvd = DVD_W'(wd_sum);
      default:            div_dvd = '0;
    endcase
  end

  s2cd_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (cmd.div_go),
    .op_in  (cmd.go_op),
    .dvd_in (div_dvd),
    .done   (div_done),
    .quo    (div_quo),
    .rem    (div_rem)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.div_cap) begin
      case (cmd.cap_op)
        s2cd_pkg::DOP_SEC:  sec_r  <= div_rem[5:0];
        s2cd_pkg::DOP_MIN:  min_r  <= div_rem[5:0];
        s2cd_pkg::DOP_HR: begin
          hour_r <= div_rem[4:0];
          days_r <= div_quo[DAYS_W-1:0];
        end
        s2cd_pkg::DOP_BASE: begin
          year_r <= YEAR_W'(base_year_r);
          r400_r <= div_rem;
          r100_r <= mod100(div_rem);
          m_r    <= 4'd0;
        end
        s2cd_pkg::DOP_C100: c100_r <= div_quo[5:0];
        default: ;
      endcase
    end else if (cmd.year_step) begin
      days_r <= days_r - DAYS_W'(ylen);
      year_r <= year_r + 1'b1;
      r400_r <= (r400_r == 9'd399) ? 9'd0 : r400_r + 1'b1;
      r100_r <= (r100_r == 7'd99) ? 7'd0 : r100_r + 1'b1;
    end else if (cmd.month_step) begin
      days_r <= days_r - DAYS_W'(mlen);
      m_r    <= m_r + 1'b1;
    end
  end

  // result registers
  assign out_valid_nxt = cmd.div_cap && (cmd.cap_op == s2cd_pkg::DOP_WD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_year_r    <= year_r[11:0];
      out_month_r   <= m_r + 4'd1;
      out_day_r     <= days_r[4:0] + 5'd1;
      out_hour_r    <= hour_r;
      out_minute_r  <= min_r;
      out_second_r  <= sec_r;
      out_weekday_r <= div_rem[2:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_year    = out_year_r;
  assign out_month   = out_month_r;
  assign out_day     = out_day_r;
  assign out_hour    = out_hour_r;
  assign out_minute  = out_minute_r;
  assign out_second  = out_second_r;
  assign out_weekday = out_weekday_r;

endmodule

`default_nettype wire

[src/s2cd_ctrl.sv]
// ----------------------------------------------------------------------------
// s2cd_ctrl - controller of the seconds to calendar converter
// sequences the seven divisions and the year and month loops
// ----------------------------------------------------------------------------
`default_nettype none

module s2cd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire s2cd_pkg::dp_stat_t    stat,
  output logic                       busy,
  output s2cd_pkg::ctrl_cmd_t        cmd
);

  function automatic logic is_div(input s2cd_pkg::state_t s);
    logic r;
    unique case (s) inside
      s2cd_pkg::ST_SEC, s2cd_pkg::ST_MIN, s2cd_pkg::ST_HR, s2cd_pkg::ST_BASE,
      s2cd_pkg::ST_C100, s2cd_pkg::ST_C400, s2cd_pkg::ST_WD: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic s2cd_pkg::div_op_t op_of(input s2cd_pkg::state_t s);
    s2cd_pkg::div_op_t op;
    unique case (s)
      s2cd_pkg::ST_MIN:  op = s2cd_pkg::DOP_MIN;
      s2cd_pkg::ST_HR:   op = s2cd_pkg::DOP_HR;
      s2cd_pkg::ST_BASE: op = s2cd_pkg::DOP_BASE;
      s2cd_pkg::ST_C100: op = s2cd_pkg::DOP_C100;
      s2cd_pkg::ST_C400: op = s2cd_pkg::DOP_C400;
      s2cd_pkg::ST_WD:   op = s2cd_pkg::DOP_WD;
      default:           op = s2cd_pkg::DOP_SEC;
    endcase
    return op;
  endfunction

  s2cd_pkg::state_t state_r;
  s2cd_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      s2cd_pkg::ST_IDLE:  if (start)           state_nxt = s2cd_pkg::ST_SEC;
      s2cd_pkg::ST_SEC:   if (stat.div_done)   state_nxt = s2cd_pkg::ST_MIN;
      s2cd_pkg::ST_MIN:   if (stat.div_done)   state_nxt = s2cd_pkg::ST_HR;
      s2cd_pkg::ST_HR:    if (stat.div_done)   state_nxt = s2cd_pkg::ST_BASE;
      s2cd_pkg::ST_BASE:  if (stat.div_done)   state_nxt = s2cd_pkg::ST_YEAR;
      s2cd_pkg::ST_YEAR:  if (stat.year_fit)   state_nxt = s2cd_pkg::ST_MONTH;
      s2cd_pkg::ST_MONTH: if (stat.month_done) state_nxt = s2cd_pkg::ST_C100;
      s2cd_pkg::ST_C100:  if (stat.div_done)   state_nxt = s2cd_pkg::ST_C400;
      s2cd_pkg::ST_C400:  if (stat.div_done)   state_nxt = s2cd_pkg::ST_WD;
      s2cd_pkg::ST_WD:    if (stat.div_done)   state_nxt = s2cd_pkg::ST_IDLE;
      default:                                 state_nxt = s2cd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= s2cd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a division is launched on entry to its state, captured when it finishes
  always_comb begin
    cmd.div_go     = is_div(state_nxt) && (state_nxt != state_r);
    cmd.go_op      = op_of(state_nxt);
    cmd.div_cap    = is_div(state_r) && stat.div_done;
    cmd.cap_op     = op_of(state_r);
    cmd.year_step  = (state_r == s2cd_pkg::ST_YEAR) && !stat.year_fit;
    cmd.month_step = (state_r == s2cd_pkg::ST_MONTH) && !stat.month_done;
  end

  assign busy = (state_r != s2cd_pkg::ST_IDLE);

endmodule

`default_nettype wire

[src/seconds_to_calendar_date.sv]
// ----------------------------------------------------------------------------
// seconds_to_calendar_date - elapsed seconds to gregorian date and weekday
// splits a 32-bit second count since 1 january of a configurable base year
// into year, month, day, hour, minute, second and weekday (0 is monday)
//
//   channel  | ports                                   | transaction
//   ---------+-----------------------------------------+---------------------------
//   input    | start, busy, in_elapsed_seconds         | start high while busy low
//   result   | out_valid, out_year .. out_weekday      | out_valid high, one cycle
//   config   | cfg_we, cfg_base_year                   | cfg_we high
//
// busy stays high through seven divisions plus one step per whole year and one per
// whole month peeled off
// the result strobe comes in the same cycle that busy falls, which may already
// accept the next transaction
// results are held in their own registers, the receiver cannot stall them
// synchronous active-low reset returns to idle with base year 2000
// ----------------------------------------------------------------------------
`default_nettype none

module seconds_to_calendar_date (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_elapsed_seconds,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_base_year,
  // result channel
  output logic             out_valid,
  output logic      [11:0] out_year,
  output logic      [3:0]  out_month,
  output logic      [4:0]  out_day,
  output logic      [4:0]  out_hour,
  output logic      [5:0]  out_minute,
  output logic      [5:0]  out_second,
  output logic      [2:0]  out_weekday
);

  // command and status between controller and datapath
  s2cd_pkg::ctrl_cmd_t cmd;
  s2cd_pkg::dp_stat_t  stat;

  // datapath: divider, year and month loops, weekday sum, result registers
  s2cd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_elapsed_seconds (in_elapsed_seconds),
    .cfg_we             (cfg_we),
    .cfg_base_year      (cfg_base_year),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_year           (out_year),
    .out_month          (out_month),
    .out_day            (out_day),
    .out_hour           (out_hour),
    .out_minute         (out_minute),
    .out_second         (out_second),
    .out_weekday        (out_weekday)
  );

  // controller: one transaction at a time, input sampled on acceptance
  s2cd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

`ifndef SYNTHESIS
  // an accepted transaction always keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted transaction");

  // a result only closes a transaction that was in flight
  a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result strobe without a transaction in flight");

  // results are never on consecutive cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // month, weekday and day stay in their ranges
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_month != 4'd0) && (out_month <= 4'd12)
                   && (out_weekday <= 3'd6) && (out_day != 5'd0)))
    else $error("result field out of range");
`endif

endmodule

`default_nettype wire
